// ----- rtl/core/fconv_pkg.sv -----
// shared constants, types and control structs of the fir convolution filter
// no dependencies
package fconv_pkg;

  localparam int MAX_TAPS      = 128;
  localparam int SAMPLE_BITS   = 16;
  localparam int ACC_BITS      = 40;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;
  localparam int TAP_AW        = $clog2(MAX_TAPS);
  localparam int CNT_W         = $clog2(MAX_TAPS + 1);
  localparam int TC_W          = 8;
  localparam int SH_W          = 5;
  localparam int CMD_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int TAP_COUNT_RST = 128;
  localparam int OUT_SHIFT_RST = 15;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;

  localparam acc_t SAT_HI = acc_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam acc_t SAT_LO = ~SAT_HI;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FILTER = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 2'd0,
    REG_OUT_SHIFT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              tap_we;
    logic [TAP_AW-1:0] tap_waddr;
    samp_t             tap_wdata;
    logic              hist_we;
    logic [TAP_AW-1:0] hist_waddr;
    samp_t             hist_wdata;
    logic              hist_clr;
    logic              rd_en;
    logic [TAP_AW-1:0] tap_raddr;
    logic [TAP_AW-1:0] hist_raddr;
  } store_req_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

// ----- rtl/core/fconv_req_if.sv -----
// input item channel: command, coefficient load fields and sample
// depends on fconv_pkg
interface fconv_req_if import fconv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TAP_AW-1:0] coef_index;
  samp_t             coef_value;
  samp_t             sample;

  modport source (output valid, cmd, coef_index, coef_value, sample, input ready);
  modport sink   (input valid, cmd, coef_index, coef_value, sample, output ready);
endinterface

// ----- rtl/core/fconv_res_if.sv -----
// result item channel: filtered sample and saturation flag
// depends on fconv_pkg
interface fconv_res_if import fconv_pkg::*; ();
  logic  valid;
  logic  ready;
  samp_t filtered;
  logic  saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

// ----- rtl/core/fconv_cfg_if.sv -----
// configuration write channel: register index and data
// depends on fconv_pkg
interface fconv_cfg_if import fconv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fir_convolution_filter.sv -----
// fir convolution filter top: sequencer, tap/history store and mac unit
// load and clear items complete in the cycle they are accepted; a filter item sweeps n taps,
// n = taps in use (1..128), one tap product per cycle through one multiplier
// the result register frees the input side while a result waits to be taken
// synchronous reset: taps and history read as zero, tap_count 128, out_shift 15
module fir_convolution_filter import fconv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fconv_req_if.sink   req,
  fconv_res_if.source res,
  fconv_cfg_if.sink   cfg
);

  store_req_t      sreq;
  mac_ctl_t        mctl;
  mac_stat_t       mstat;
  samp_t           tap_q;
  samp_t           hist_q;
  logic [SH_W-1:0] shift;

  fconv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cfg   (cfg),
    .mstat (mstat),
    .sreq  (sreq),
    .mctl  (mctl),
    .shift (shift)
  );

  fconv_store u_store (
    .clk    (clk),
    .rst    (rst),
    .sreq   (sreq),
    .tap_q  (tap_q),
    .hist_q (hist_q)
  );

  fconv_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mctl),
    .tap_q  (tap_q),
    .hist_q (hist_q),
    .shift  (shift),
    .res    (res),
    .stat   (mstat)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    mstat.busy |-> !req.ready)
    else $error("item accepted while mac pipeline busy");

  a_filter_blocks_next: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd == CMD_FILTER) |=> !req.ready)
    else $error("input not held off after filter item");

  a_result_from_mac: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(mstat.busy))
    else $error("result appeared without mac activity");

  a_no_issue_with_write: assert property (@(posedge clk) disable iff (rst)
    sreq.rd_en |-> !(sreq.tap_we || sreq.hist_we || sreq.hist_clr))
    else $error("store written during tap sweep");

endmodule

// ----- rtl/core/fconv_store.sv -----
// tap and history memories, registered reads, per-entry valid bits
// depends on fconv_pkg
module fconv_store import fconv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t sreq,
  output samp_t      tap_q,
  output samp_t      hist_q
);

  logic [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]    tap_vld;
  logic [MAX_TAPS-1:0]    hist_vld;
  logic [SAMPLE_BITS-1:0] tap_rd;
  logic [SAMPLE_BITS-1:0] hist_rd;
  logic                   tap_rd_vld;
  logic                   hist_rd_vld;

  always_ff @(posedge clk) begin
    if (sreq.tap_we) begin
      tap_mem[sreq.tap_waddr] <= sreq.tap_wdata;
    end
    if (sreq.hist_we) begin
      hist_mem[sreq.hist_waddr] <= sreq.hist_wdata;
    end
    if (sreq.rd_en) begin
      tap_rd  <= tap_mem[sreq.tap_raddr];
      hist_rd <= hist_mem[sreq.hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_vld     <= '0;
      hist_vld    <= '0;
      tap_rd_vld  <= 1'b0;
      hist_rd_vld <= 1'b0;
    end else begin
      if (sreq.tap_we) begin
        tap_vld[sreq.tap_waddr] <= 1'b1;
      end
      if (sreq.hist_clr) begin
        hist_vld <= '0;
      end else if (sreq.hist_we) begin
        hist_vld[sreq.hist_waddr] <= 1'b1;
      end
      if (sreq.rd_en) begin
        tap_rd_vld  <= tap_vld[sreq.tap_raddr];
        hist_rd_vld <= hist_vld[sreq.hist_raddr];
      end
    end
  end

  // entries never written read as zero
  assign tap_q  = tap_rd_vld  ? samp_t'(tap_rd)  : '0;
  assign hist_q = hist_rd_vld ? samp_t'(hist_rd) : '0;

endmodule

// ----- rtl/core/fconv_ctrl.sv -----
// command decode, config registers and tap sequencer
// depends on fconv_pkg and the request and config interfaces
module fconv_ctrl import fconv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  fconv_req_if.sink       req,
  fconv_cfg_if.sink       cfg,
  input  mac_stat_t       mstat,
  output store_req_t      sreq,
  output mac_ctl_t        mctl,
  output logic [SH_W-1:0] shift
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [TC_W-1:0]   tap_count;
  logic [SH_W-1:0]   out_shift;
  logic [TAP_AW-1:0] head;
  logic [TAP_AW-1:0] head_inc;
  logic [TAP_AW-1:0] pos;
  logic [TAP_AW-1:0] tap_addr;
  logic [CNT_W-1:0]  remain;
  logic [CNT_W-1:0]  n_eff;
  logic              accept;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign shift     = out_shift;

  assign head_inc = (head == TAP_AW'(MAX_TAPS - 1)) ? '0 : head + TAP_AW'(1);

  always_comb begin
    if (tap_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(tap_count) > CNT_W'(MAX_TAPS)) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(tap_count);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.cmd == CMD_FILTER) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (remain == CNT_W'(1)) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!mstat.busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TC_W'(TAP_COUNT_RST);
      out_shift <= SH_W'(OUT_SHIFT_RST);
      head      <= '0;
      pos       <= '0;
      tap_addr  <= '0;
      remain    <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TAP_COUNT: tap_count <= cfg.data[TC_W-1:0];
          REG_OUT_SHIFT: out_shift <= cfg.data[SH_W-1:0];
          default: ;
        endcase
      end
      if (accept && req.cmd == CMD_FILTER) begin
        pos      <= head;
        tap_addr <= '0;
        remain   <= n_eff;
        head     <= head_inc;
      end else if (accept && req.cmd == CMD_CLEAR) begin
        head <= '0;
      end
      if (state == ST_RUN) begin
        tap_addr <= tap_addr + TAP_AW'(1);
        pos      <= (pos == '0) ? TAP_AW'(MAX_TAPS - 1) : pos - TAP_AW'(1);
        remain   <= remain - CNT_W'(1);
      end
    end
  end

  always_comb begin
    sreq.tap_we     = accept && req.cmd == CMD_LOAD;
    sreq.tap_waddr  = req.coef_index;
    sreq.tap_wdata  = req.coef_value;
    sreq.hist_we    = accept && req.cmd == CMD_FILTER;
    sreq.hist_waddr = head;
    sreq.hist_wdata = req.sample;
    sreq.hist_clr   = accept && req.cmd == CMD_CLEAR;
    sreq.rd_en      = (state == ST_RUN);
    sreq.tap_raddr  = tap_addr;
    sreq.hist_raddr = pos;
    mctl.issue      = (state == ST_RUN);
    mctl.first      = (tap_addr == '0);
    mctl.last       = (remain == CNT_W'(1));
  end

endmodule

// ----- rtl/core/fconv_mac.sv -----
// multiply-accumulate, rounding, shift, saturation and result register
// depends on fconv_pkg and the result interface
module fconv_mac import fconv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  mac_ctl_t        ctl,
  input  samp_t           tap_q,
  input  samp_t           hist_q,
  input  logic [SH_W-1:0] shift,
  fconv_res_if.source     res,
  output mac_stat_t       stat
);

  logic  d1_v;
  logic  d1_first;
  logic  d1_last;
  prod_t prod;
  logic  p_v;
  logic  p_first;
  logic  p_last;
  acc_t  acc;
  logic  a_done;
  acc_t  rnd;
  logic  rnd_v;
  acc_t  rnd_bit;
  acc_t  shifted;
  logic  move;
  logic  out_v;
  samp_t out_val;
  logic  out_sat;

  assign rnd_bit = (shift == '0) ? '0 : acc_t'(ACC_BITS'(1) << (shift - SH_W'(1)));
  assign shifted = rnd >>> shift;
  assign move    = rnd_v && (!out_v || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v   <= 1'b0;
      p_v    <= 1'b0;
      a_done <= 1'b0;
      rnd_v  <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      d1_v   <= ctl.issue;
      p_v    <= d1_v;
      a_done <= p_v && p_last;
      if (a_done) begin
        rnd_v <= 1'b1;
      end else if (move) begin
        rnd_v <= 1'b0;
      end
      if (move) begin
        out_v <= 1'b1;
      end else if (res.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_first <= ctl.first;
    d1_last  <= ctl.last;
    prod     <= tap_q * hist_q;
    p_first  <= d1_first;
    p_last   <= d1_last;
    if (p_v) begin
      acc <= (p_first ? acc_t'(0) : acc) + acc_t'(prod);
    end
    if (a_done) begin
      rnd <= acc + rnd_bit;
    end
    if (move) begin
      if (shifted > SAT_HI) begin
        out_val <= SAT_HI[SAMPLE_BITS-1:0];
        out_sat <= 1'b1;
      end else if (shifted < SAT_LO) begin
        out_val <= SAT_LO[SAMPLE_BITS-1:0];
        out_sat <= 1'b1;
      end else begin
        out_val <= shifted[SAMPLE_BITS-1:0];
        out_sat <= 1'b0;
      end
    end
  end

  assign res.valid     = out_v;
  assign res.filtered  = out_val;
  assign res.saturated = out_sat;
  assign stat.busy     = d1_v || p_v || a_done || rnd_v;

endmodule

// ----- test/fir_output_checker.sv -----
`timescale 1ns / 100ps
// output checker for the fir convolution filter: watches the item, result and register channels
// keeps its own tap store, sample history and settings, predicts each filtered sample and compares
// depends on fconv_pkg and the fconv_req_if, fconv_res_if and fconv_cfg_if interfaces
module fir_output_checker import fconv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  fconv_req_if  req,
  fconv_res_if  res,
  fconv_cfg_if  cfg,
  output int    failures,
  output int    outstanding
);

  localparam int   REPORT_LIMIT = 10;
  localparam acc_t OUT_MAX      = acc_t'(32767);
  localparam acc_t OUT_MIN      = acc_t'(-32768);

  typedef struct packed {
    samp_t filtered;
    logic  saturated;
  } filter_result_t;

  samp_t             coef_store  [MAX_TAPS];
  samp_t             sample_line [MAX_TAPS];
  logic [TAP_AW-1:0] write_slot;
  logic [TC_W-1:0]   taps_in_use;
  logic [SH_W-1:0]   shift_amount;
  filter_result_t    expected_outputs [$];
  int                fail_total;

  // sum of products back from the newest sample, rounded, scaled and clamped
  function automatic filter_result_t convolve_history();
    acc_t              acc;
    acc_t              scaled;
    prod_t             product;
    logic [TAP_AW-1:0] pos;
    int                n;
    int                k;
    filter_result_t    r;
    if (taps_in_use == 0) n = 1;
    else if (taps_in_use > MAX_TAPS) n = MAX_TAPS;
    else n = int'(taps_in_use);
    acc = '0;
    pos = write_slot;
    for (k = 0; k < n; k++) begin
      product = coef_store[k] * sample_line[pos];
      acc = acc + acc_t'(product);
      pos = pos - TAP_AW'(1);
    end
    if (shift_amount != 0) acc = acc + (acc_t'(1) <<< (shift_amount - SH_W'(1)));
    scaled = acc >>> shift_amount;
    if (scaled > OUT_MAX) begin
      r.filtered = samp_t'(OUT_MAX);
      r.saturated = 1'b1;
    end else if (scaled < OUT_MIN) begin
      r.filtered = samp_t'(OUT_MIN);
      r.saturated = 1'b1;
    end else begin
      r.filtered = samp_t'(scaled);
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < MAX_TAPS; i++) begin
        coef_store[i] = '0;
        sample_line[i] = '0;
      end
      write_slot = '0;
      taps_in_use = TC_W'(TAP_COUNT_RST);
      shift_amount = SH_W'(OUT_SHIFT_RST);
      expected_outputs.delete();
      fail_total = 0;
      failures <= 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TAP_COUNT: taps_in_use = cfg.data[TC_W-1:0];
          REG_OUT_SHIFT: shift_amount = cfg.data[SH_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.cmd)
          CMD_LOAD: coef_store[req.coef_index] = req.coef_value;
          CMD_FILTER: begin
            sample_line[write_slot] = req.sample;
            expected_outputs.push_back(convolve_history());
            write_slot = write_slot + TAP_AW'(1);
          end
          CMD_CLEAR: begin
            for (i = 0; i < MAX_TAPS; i++) sample_line[i] = '0;
            write_slot = '0;
          end
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_outputs.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected result %0d/%0b with nothing pending", $realtime,
                     res.filtered, res.saturated);
        end else begin
          want = expected_outputs.pop_front();
          if (res.filtered !== want.filtered || res.saturated !== want.saturated) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: result mismatch: expected %0d/%0b, got %0d/%0b", $realtime,
                       want.filtered, want.saturated, res.filtered, res.saturated);
          end
        end
      end
      failures <= fail_total;
      outstanding <= expected_outputs.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// regression top for fir_convolution_filter: clock, reset, item and register stimulus, verdict
// depends on fconv_pkg, the channel interfaces, the filter rtl and fir_output_checker
module tb_top import fconv_pkg::*; ();

  localparam int CLK_PERIOD      = 4;
  localparam int LIMIT_CYCLES    = 1_600_000;
  localparam int ITEM_TARGET     = 2000;
  localparam int HOLD_OFF_AFTER  = 60;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 200;

  localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;

  localparam samp_t S_MAX = samp_t'(16'h7fff);
  localparam samp_t S_MIN = samp_t'(16'h8000);

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   sent;
  int   burst_left;

  fconv_req_if req ();
  fconv_res_if res ();
  fconv_cfg_if cfg ();

  fir_convolution_filter dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  fir_output_checker output_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic samp_t pick_value();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return samp_t'($urandom);
    endcase
  endfunction

  // offer one item, then keep the burst going or open a gap
  task automatic send_command(input logic [CMD_W-1:0] c, input logic [TAP_AW-1:0] idx,
                              input samp_t coef, input samp_t smp);
    req.valid = 1'b1;
    req.cmd = c;
    req.coef_index = idx;
    req.coef_value = coef;
    req.sample = smp;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_filter(input samp_t smp);
    send_command(CMD_FILTER, TAP_AW'($urandom), samp_t'($urandom), smp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_until_drained();
    req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [TC_W-1:0] tc, input logic [SH_W-1:0] sh);
    logic [CFG_DATA_W-SH_W-1:0] pad;
    pad = (CFG_DATA_W - SH_W)'($urandom);
    wait_until_drained();
    if ($urandom_range(0, 1) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_TAP_COUNT, tc);
    write_reg(REG_OUT_SHIFT, {pad, sh});
  endtask

  // one record: clear, random body, then zeros to flush the convolution tail
  task automatic run_record(input int used_taps, input int body);
    int k;
    int roll;
    logic [TAP_AW-1:0] idx;
    send_command(CMD_CLEAR, TAP_AW'($urandom), samp_t'($urandom), samp_t'($urandom));
    for (k = 0; k < body; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        idx = ($urandom_range(0, 1) == 0) ? TAP_AW'($urandom_range(0, used_taps - 1))
                                          : TAP_AW'($urandom);
        send_command(CMD_LOAD, idx, pick_value(), samp_t'($urandom));
      end else if (roll < 11) begin
        send_command(CMD_CLEAR, TAP_AW'($urandom), samp_t'($urandom), samp_t'($urandom));
      end else if (roll < 14) begin
        send_command(CMD_RESERVED, TAP_AW'($urandom), samp_t'($urandom), samp_t'($urandom));
      end else begin
        send_filter(pick_value());
      end
    end
    wait_until_drained();
    for (k = 0; k < used_taps - 1; k++) send_filter('0);
  endtask

  task automatic run_phase(input logic [TC_W-1:0] tc, input logic [SH_W-1:0] sh,
                           input int quota);
    int used;
    int start;
    int k;
    apply_settings(tc, sh);
    if (tc == 0) used = 1;
    else if (tc > MAX_TAPS) used = MAX_TAPS;
    else used = int'(tc);
    start = sent;
    for (k = 0; k < used; k++)
      send_command(CMD_LOAD, TAP_AW'(k), pick_value(), samp_t'($urandom));
    while (sent - start < quota) run_record(used, $urandom_range(10, 60));
  endtask

  // receiver: changing stall patterns, one long hold-off to back up the filter
  initial begin
    int  mode;
    int  served;
    int  tick;
    logic held;
    res.ready = 1'b0;
    mode = 0;
    served = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) served++;
      @(negedge clk);
      if (!held && served >= HOLD_OFF_AFTER && req.valid) begin
        held = 1'b1;
        res.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (tick % 48 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0: res.ready = 1'b1;
        1: res.ready = ($urandom_range(0, 1) == 1);
        2: res.ready = ($urandom_range(0, 3) != 0);
        default: res.ready = ((tick % 7) < 4);
      endcase
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_LOAD;
    req.coef_index = '0;
    req.coef_value = '0;
    req.sample = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_TAP_COUNT;
    cfg.data = '0;
    sent = 0;
    burst_left = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty tap store, extreme taps, ignored command, clear, alternating bit patterns
    send_filter(S_MAX);
    send_command(CMD_LOAD, 7'd0, S_MAX, '0);
    send_command(CMD_LOAD, 7'd1, S_MIN, '0);
    send_command(CMD_LOAD, 7'd127, '1, '0);
    send_command(CMD_RESERVED, 7'd2, S_MAX, S_MIN);
    send_filter(S_MIN);
    send_filter(S_MIN);
    send_filter(S_MAX);
    send_command(CMD_CLEAR, 7'd127, '1, '1);
    send_filter(S_MIN);
    send_filter(S_MIN);
    send_command(CMD_LOAD, 7'd64, samp_t'(16'h5555), '0);
    send_command(CMD_LOAD, 7'd63, samp_t'(16'haaaa), '0);
    send_filter(samp_t'(16'h5555));
    send_filter(samp_t'(16'haaaa));
    // zero taps acts as one, no shift saturates both ways
    apply_settings(8'd0, 5'd0);
    send_filter(S_MAX);
    send_filter(S_MIN);
    send_filter(samp_t'(1));
    apply_settings(8'd128, 5'd31);
    send_filter(S_MIN);
    send_filter(S_MAX);

    run_phase(8'd1, 5'd15, 150);
    run_phase(8'd0, 5'd0, 150);
    run_phase(8'd255, 5'd31, 250);
    run_phase(8'd128, 5'd15, 250);
    run_phase(8'd2, 5'd1, 150);
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0)
        run_phase(TC_W'($urandom_range(25, 255)), SH_W'($urandom), 200);
      else
        run_phase(TC_W'($urandom_range(0, 24)), SH_W'($urandom), 200);
    end

    req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("fir_convolution_filter regression: pass");
    else
      $display("fir_convolution_filter regression: fail");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("fir_convolution_filter regression: fail");
    $finish;
  end

endmodule
